// ===== design/nearest_path_point_search_top_defines.svh =====
// Assertion macros shared by the nearest path point search RTL.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef NEAREST_PATH_POINT_SEARCH_TOP_DEFINES_SVH
`define NEAREST_PATH_POINT_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define NPPS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("npps same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define NPPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("npps next-cycle check failed");

`endif

// ===== design/npps_pkg.sv =====
// Package for the nearest path point search block.
// Holds codes, state type and the scan tag struct; no dependencies.
package npps_pkg;

    localparam int IDX_W    = 10;
    localparam int STATUS_W = 2;

    typedef enum logic [0:0] {
        FUNC_APPEND = 1'b0,
        FUNC_QUERY  = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_MATCH    = 2'd0,
        ST_APPENDED = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_POINT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    // Travels with each point read through the distance pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

endpackage

// ===== design/npps_mem.sv =====
// Point store: simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. No dependencies.
module npps_mem #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/npps_dist.sv =====
// Two-stage squared Euclidean distance pipeline with saturation at DIST_BITS bits.
// Uses npps_pkg for the scan tag that travels alongside each point.
module npps_dist #(
    parameter int COORD_BITS = 24,
    parameter int IDX_BITS   = 10,
    parameter int DIST_BITS  = 49
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  npps_pkg::t_tag               i_tag,
    input  logic [IDX_BITS-1:0]          i_index,
    input  logic signed [COORD_BITS-1:0] i_qx,
    input  logic signed [COORD_BITS-1:0] i_qy,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    output npps_pkg::t_tag               o_tag,
    output logic [IDX_BITS-1:0]          o_index,
    output logic [DIST_BITS-1:0]         o_dist
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 1;

    logic signed [COORD_BITS:0] diff_x;
    logic signed [COORD_BITS:0] diff_y;
    logic [COORD_BITS:0]        neg_x;
    logic [COORD_BITS:0]        neg_y;
    logic [COORD_BITS-1:0]      mag_x;
    logic [COORD_BITS-1:0]      mag_y;
    logic [SQ_W-1:0]            r_sq_x;
    logic [SQ_W-1:0]            r_sq_y;
    npps_pkg::t_tag             r_tag1;
    logic [IDX_BITS-1:0]        r_idx1;
    logic [SUM_W-1:0]           sum;
    logic [DIST_BITS-1:0]       dist_sat;
    npps_pkg::t_tag             r_tag2;
    logic [IDX_BITS-1:0]        r_idx2;
    logic [DIST_BITS-1:0]       r_dist;

    // Differences and their magnitudes
    assign diff_x = $signed({i_qx[COORD_BITS-1], i_qx}) - $signed({i_px[COORD_BITS-1], i_px});
    assign diff_y = $signed({i_qy[COORD_BITS-1], i_qy}) - $signed({i_py[COORD_BITS-1], i_py});
    assign neg_x  = -diff_x;
    assign neg_y  = -diff_y;
    assign mag_x  = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
    assign mag_y  = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];

    // Stage 1: square each term
    always_ff @(posedge i_clk) begin
        r_sq_x <= mag_x * mag_x;
        r_sq_y <= mag_y * mag_y;
        r_idx1 <= i_index;
    end

    // Stage 2: add and saturate
    assign sum = {1'b0, r_sq_x} + {1'b0, r_sq_y};

    generate
        if (SUM_W > DIST_BITS) begin : g_sat
            assign dist_sat = (|sum[SUM_W-1:DIST_BITS]) ? '1 : sum[DIST_BITS-1:0];
        end else begin : g_nosat
            assign dist_sat = DIST_BITS'(sum);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_dist <= dist_sat;
        r_idx2 <= r_idx1;
    end

    // Tag pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    assign o_tag   = r_tag2;
    assign o_index = r_idx2;
    assign o_dist  = r_dist;

endmodule

// ===== design/nearest_path_point_search_top.sv =====
// Nearest path point search: top level with control, point count and best tracking.
// Depends on npps_pkg, npps_mem, npps_dist and the assertion macro header.
//
// An append transaction stores one point (or reports the store full) and its
// result strobes on o_result_valid in the next cycle; busy stays low, so a new
// transaction can be started every cycle. A query over N = point_count -
// start_index stored points holds busy while it scans and its result strobes
// in the cycle busy falls; the scan reads one point per cycle from the point
// memory. A query with nothing to search answers in the next cycle.
// Each result is on the output ports for exactly one cycle and cannot be
// stalled: the receiver must take it when o_result_valid is high. The start
// index register is always ready and should be written only while idle.
`include "nearest_path_point_search_top_defines.svh"

module nearest_path_point_search_top #(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [0:0]                          i_func,
    input  logic signed [COORD_BITS-1:0]        i_pos_x,
    input  logic signed [COORD_BITS-1:0]        i_pos_y,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [npps_pkg::IDX_W-1:0]          i_cfg_data,
    output logic                                o_result_valid,
    output logic [npps_pkg::IDX_W-1:0]          o_match_index,
    output logic [npps_pkg::STATUS_W-1:0]       o_status
);

    localparam int AW      = $clog2(MAX_POINTS);
    localparam int CW      = $clog2(MAX_POINTS + 1);
    localparam int CMPW    = (CW > npps_pkg::IDX_W) ? CW : npps_pkg::IDX_W;
    localparam int SUM_W   = 2 * COORD_BITS + 1;
    localparam int DIST_W  = (SUM_W > 64) ? 64 : SUM_W;
    localparam int WORD_W  = 2 * COORD_BITS;

    npps_pkg::t_state                r_state;
    npps_pkg::t_state                n_state;
    logic [CW-1:0]                   r_count;
    logic [npps_pkg::IDX_W-1:0]      r_start_index;
    logic [AW-1:0]                   r_addr;
    logic signed [COORD_BITS-1:0]    r_qx;
    logic signed [COORD_BITS-1:0]    r_qy;
    npps_pkg::t_tag                  r_rd_tag;
    logic [AW-1:0]                   r_rd_idx;
    logic                            r_have_best;
    logic [DIST_W-1:0]               r_best_d;
    logic [AW-1:0]                   r_best_idx;
    logic                            r_res_valid;
    logic [npps_pkg::IDX_W-1:0]      r_res_index;
    npps_pkg::t_status               r_res_status;

    logic                            accept;
    logic                            is_query;
    logic                            full;
    logic                            in_range;
    logic [CMPW-1:0]                 start_ext;
    logic [CMPW-1:0]                 count_ext;
    logic [CW-1:0]                   count_m1;
    logic                            scan_last;
    logic                            rd_en;
    npps_pkg::t_tag                  issue_tag;
    logic                            mem_we;
    logic [WORD_W-1:0]               rd_word;
    npps_pkg::t_tag                  dist_tag;
    logic [AW-1:0]                   dist_idx;
    logic [DIST_W-1:0]               dist_d;
    logic                            take;
    logic                            scan_done;

    // Handshake decode
    assign busy        = (r_state != npps_pkg::S_IDLE);
    assign accept      = start && !busy;
    assign is_query    = (i_func == npps_pkg::FUNC_QUERY);
    assign full        = (r_count == CW'(MAX_POINTS));
    assign start_ext   = CMPW'(r_start_index);
    assign count_ext   = CMPW'(r_count);
    assign in_range    = (start_ext < count_ext);
    assign count_m1    = r_count - CW'(1);
    assign scan_last   = (r_addr == count_m1[AW-1:0]);
    assign mem_we      = accept && !is_query && !full;
    assign o_cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_index <= '0;
        end else if (i_cfg_valid) begin
            r_start_index <= i_cfg_data;
        end
    end

    // Point count: advance on each stored append
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (mem_we) begin
            r_count <= r_count + CW'(1);
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and scan issue
    always_comb begin
        n_state   = r_state;
        rd_en     = 1'b0;
        issue_tag = '0;
        unique case (r_state)
            npps_pkg::S_IDLE: begin
                if (accept && is_query && in_range) begin
                    n_state = npps_pkg::S_SCAN;
                end
            end
            npps_pkg::S_SCAN: begin
                rd_en          = 1'b1;
                issue_tag.valid = 1'b1;
                issue_tag.last  = scan_last;
                if (scan_last) begin
                    n_state = npps_pkg::S_DRAIN;
                end
            end
            npps_pkg::S_DRAIN: begin
                if (scan_done) begin
                    n_state = npps_pkg::S_IDLE;
                end
            end
            default: n_state = npps_pkg::S_IDLE;
        endcase
    end

    // Query position and scan address
    always_ff @(posedge i_clk) begin
        if (accept && is_query) begin
            r_qx   <= i_pos_x;
            r_qy   <= i_pos_y;
            r_addr <= start_ext[AW-1:0];
        end else if (rd_en) begin
            r_addr <= r_addr + AW'(1);
        end
    end

    // Align tag and index with the memory read latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= '0;
        end else begin
            r_rd_tag <= issue_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
    end

    npps_mem #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_pos_x, i_pos_y}),
        .i_re    (rd_en),
        .i_raddr (r_addr),
        .o_rdata (rd_word)
    );

    npps_dist #(
        .COORD_BITS (COORD_BITS),
        .IDX_BITS   (AW),
        .DIST_BITS  (DIST_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_index (r_rd_idx),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .i_px    (rd_word[WORD_W-1:COORD_BITS]),
        .i_py    (rd_word[COORD_BITS-1:0]),
        .o_tag   (dist_tag),
        .o_index (dist_idx),
        .o_dist  (dist_d)
    );

    // Keep the earliest strictly smaller distance
    assign take      = !r_have_best || (dist_d < r_best_d);
    assign scan_done = dist_tag.valid && dist_tag.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best <= 1'b0;
        end else if (accept) begin
            r_have_best <= 1'b0;
        end else if (dist_tag.valid) begin
            r_have_best <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dist_tag.valid && take) begin
            r_best_d   <= dist_d;
            r_best_idx <= dist_idx;
        end
    end

    // Result strobe: one cycle per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= (accept && (!is_query || !in_range)) || scan_done;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (accept && !is_query) begin
            r_res_index  <= '0;
            r_res_status <= full ? npps_pkg::ST_FULL : npps_pkg::ST_APPENDED;
        end else if (accept && !in_range) begin
            r_res_index  <= r_start_index;
            r_res_status <= npps_pkg::ST_NO_POINT;
        end else if (scan_done) begin
            r_res_index  <= npps_pkg::IDX_W'(take ? dist_idx : r_best_idx);
            r_res_status <= npps_pkg::ST_MATCH;
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_match_index  = r_res_index;
    assign o_status       = r_res_status;

    // Checks
    `NPPS_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CW'(MAX_POINTS))
    `NPPS_ASSERT_NEXT(a_query_busy, accept && is_query && in_range, busy && !o_result_valid)
    `NPPS_ASSERT_NEXT(a_match_out, scan_done, o_result_valid && (o_status == npps_pkg::ST_MATCH) && !busy)
    `NPPS_ASSERT_IMPL(a_no_scan_result, r_state == npps_pkg::S_SCAN, !o_result_valid)

endmodule
